// ===== rtl/core/rte_pkg.sv =====
`timescale 1ns / 1ps
package rte_pkg;

  localparam int unsigned ROUTE_ENTRIES = 32;
  localparam int unsigned IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ROUTE_ENTRIES + 1);

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LIFE_W = 31;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned EXP_W  = 33;
  localparam int unsigned RMV_W  = 6;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(300000);
  localparam logic [RMV_W-1:0]  REMOVED_MAX    = '1;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_INVAL  = 2'd2,
    REQ_EXPIRE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e         req_type;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] next_hop_addr;
    logic [BYTE_W-1:0] hop_cnt;
    logic [BYTE_W-1:0] path_metric;
    logic [BYTE_W-1:0] xport_id;
    logic [TIME_W-1:0] now_ms;
  } rte_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [ADDR_W-1:0] out_next_hop;
    logic [BYTE_W-1:0] out_hop_count;
    logic [BYTE_W-1:0] out_metric;
    logic [BYTE_W-1:0] out_transport;
    logic [RMV_W-1:0]  removed_count;
  } rte_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] nh_addr;
    logic [BYTE_W-1:0] hops;
    logic [BYTE_W-1:0] metric;
    logic [BYTE_W-1:0] transport;
    logic [EXP_W-1:0]  expiry;
  } route_t;

endpackage

// ===== rtl/core/rte_req_if.sv =====
`timescale 1ns / 1ps
interface rte_req_if import rte_pkg::*; ();
  logic     valid;
  logic     ready;
  rte_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/rte_rsp_if.sv =====
`timescale 1ns / 1ps
interface rte_rsp_if import rte_pkg::*; ();
  logic     valid;
  logic     ready;
  rte_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/route_table_engine_top.sv =====
`timescale 1ns / 1ps
// A request is accepted only in the idle state; the scan then reads the route memory one
// entry per cycle through its single read port, and a write-back state writes any update
// and registers the result before the next request is accepted.
// A new request is taken while the previous result still waits in the output register.
// Reset (async, active low) clears all valid bits, the sequencer and the output valid;
// the lifetime register returns to 300000 ms. No clearing pass is needed.
module route_table_engine_top import rte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LIFE_W-1:0] cfg_wdata_i,
  rte_req_if.sink           req_i,
  rte_rsp_if.source         rsp_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [LIFE_W-1:0]        lifetime_q;
  rte_req_t                 req_q;
  logic [EXP_W-1:0]         expiry_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     chk_en_q;
  logic [IDX_W-1:0]         chk_idx_q;
  logic [ROUTE_ENTRIES-1:0] valid_q;
  route_t                   mem [ROUTE_ENTRIES];
  route_t                   rd_q;
  logic                     hit_q;
  logic                     hit_ok_q;
  logic [IDX_W-1:0]         hit_idx_q;
  route_t                   hit_route_q;
  logic                     free_q;
  logic [IDX_W-1:0]         free_idx_q;
  logic [RMV_W-1:0]         removed_q;
  logic                     rsp_vld_q;
  rte_rsp_t                 rsp_q, rsp_d;

  logic             req_acc;
  logic [IDX_W-1:0] scan_idx;
  logic             issue;
  logic             ent_vld;
  logic             last_chk;
  logic             match_now;
  logic             free_now;
  logic             clr_now;
  logic             fin_go;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  route_t           mem_wd;
  logic             set_vld;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign scan_idx    = cnt_q[IDX_W-1:0];
  assign issue       = (state_q == ST_SCAN) && (cnt_q < CNT_W'(ROUTE_ENTRIES));
  assign ent_vld     = valid_q[chk_idx_q];
  assign last_chk    = chk_en_q && (chk_idx_q == IDX_W'(ROUTE_ENTRIES - 1));

  assign match_now = chk_en_q && ent_vld && !hit_q && (rd_q.dest == req_q.dest_addr);
  assign free_now  = chk_en_q && !ent_vld && !free_q;
  assign clr_now   = chk_en_q && ent_vld &&
                     (((req_q.req_type == REQ_INVAL) && (rd_q.nh_addr == req_q.next_hop_addr)) ||
                      ((req_q.req_type == REQ_EXPIRE) && ({1'b0, req_q.now_ms} > rd_q.expiry)));

  assign fin_go  = (state_q == ST_FIN) && (!rsp_vld_q || rsp_o.ready);
  assign mem_we  = fin_go && (req_q.req_type == REQ_UPDATE) && (hit_q ? hit_ok_q : free_q);
  assign mem_wa  = hit_q ? hit_idx_q : free_idx_q;
  assign set_vld = fin_go && (req_q.req_type == REQ_UPDATE) && !hit_q && free_q;

  always_comb begin
    mem_wd.dest      = req_q.dest_addr;
    mem_wd.nh_addr   = req_q.next_hop_addr;
    mem_wd.hops      = req_q.hop_cnt;
    mem_wd.metric    = req_q.path_metric;
    mem_wd.transport = req_q.xport_id;
    mem_wd.expiry    = expiry_q;
  end

  always_comb begin
    rsp_d = '0;
    unique case (req_q.req_type)
      REQ_UPDATE: begin
        rsp_d.status = (!hit_q && !free_q) ? STATUS_FULL : STATUS_OK;
      end
      REQ_LOOKUP: begin
        if (hit_q) begin
          rsp_d.found         = 1'b1;
          rsp_d.out_next_hop  = hit_route_q.nh_addr;
          rsp_d.out_hop_count = hit_route_q.hops;
          rsp_d.out_metric    = hit_route_q.metric;
          rsp_d.out_transport = hit_route_q.transport;
        end else begin
          rsp_d.status = STATUS_NOT_FOUND;
        end
      end
      REQ_INVAL, REQ_EXPIRE: begin
        rsp_d.removed_count = removed_q;
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (req_acc) state_d = ST_SCAN;
      ST_SCAN: if (last_chk) state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lifetime_q <= LIFETIME_RESET;
      cnt_q      <= '0;
      chk_en_q   <= 1'b0;
      valid_q    <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      removed_q  <= '0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      chk_en_q <= issue;
      if (cfg_we_i) lifetime_q <= cfg_wdata_i;
      if (req_acc) begin
        cnt_q     <= '0;
        hit_q     <= 1'b0;
        free_q    <= 1'b0;
        removed_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (match_now) hit_q <= 1'b1;
      if (free_now) free_q <= 1'b1;
      if (clr_now) begin
        valid_q[chk_idx_q] <= 1'b0;
        if (removed_q != REMOVED_MAX) removed_q <= removed_q + RMV_W'(1);
      end
      if (set_vld) valid_q[free_idx_q] <= 1'b1;
      if (fin_go) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= scan_idx;
    if (req_acc) begin
      req_q    <= req_i.payload;
      expiry_q <= {1'b0, req_i.payload.now_ms} + {2'b00, lifetime_q};
    end
    if (match_now) begin
      hit_idx_q   <= chk_idx_q;
      hit_ok_q    <= (req_q.path_metric <= rd_q.metric);
      hit_route_q <= rd_q;
    end
    if (free_now) free_idx_q <= chk_idx_q;
    if (fin_go) rsp_q <= rsp_d;
  end

  // route memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[scan_idx];
  end

  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  a_wr_only_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_FIN))
    else $error("route write outside write-back");

  a_acc_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == ST_SCAN) && (cnt_q == '0))
    else $error("accepted request did not start a scan");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && rsp_q.found) |-> (rsp_q.status == STATUS_OK) && (rsp_q.removed_count == '0))
    else $error("found result carries bad status or count");

  a_clr_not_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_now |-> (state_q == ST_SCAN) && !mem_we)
    else $error("entry cleared outside invalidate or expire scan");

  a_scan_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |-> !chk_en_q || $past(state_q == ST_SCAN))
    else $error("entry check outside scan");

endmodule
